// ----- hdl/dcwf_pkg.sv -----
// ----------------------------------------------------------------------------
// dcwf_pkg
// Shared constants, types and helpers for the debug channel word framer.
// ----------------------------------------------------------------------------
package dcwf_pkg;

  // Transmit store depth; power of two, 16 .. 2048.
  localparam int BUFFER_DEPTH = 2048;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int NUM_BANKS    = 4;
  localparam int LANE_W       = $clog2(NUM_BANKS);
  localparam int ROW_W        = PTR_W - LANE_W;
  localparam int BANK_DEPTH   = BUFFER_DEPTH / NUM_BANKS;
  localparam int CNT_W        = 11;
  localparam int WORD_W       = 32;

  // Stream layout
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 96;

  // func codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POLL = 1'b1;

  // Item context carried from the pointer stage to the output stage.
  typedef struct packed {
    logic              accepted;
    logic              in_taken;
    logic [2:0]        rx_count;
    logic [WORD_W-1:0] rx_data;
    logic              tx_valid;
    logic              tx_is_len;
    logic [WORD_W-1:0] tx_len;
    logic [2:0]        tx_cnt;
    logic [LANE_W-1:0] rd_lane;
    logic [CNT_W-1:0]  pending_count;
    logic [CNT_W-1:0]  free_space;
  } dcwf_meta_t;

  // Mask covering the low n bytes of a word (n = 0..4).
  function automatic logic [WORD_W-1:0] byte_mask(input logic [2:0] n);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < n) m[8*k +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

// ----- hdl/dcwf_tx_bank.sv -----
// ----------------------------------------------------------------------------
// dcwf_tx_bank
// One byte lane of the transmit store: single write port, registered read.
// ----------------------------------------------------------------------------
module dcwf_tx_bank
  import dcwf_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [ROW_W-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic             re,
  input  logic [ROW_W-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- hdl/dcwf_ctrl.sv -----
// ----------------------------------------------------------------------------
// dcwf_ctrl
// Pointer and frame counter stage: store addressing, receive and transmit
// framing decisions for each accepted item.
// ----------------------------------------------------------------------------
module dcwf_ctrl
  import dcwf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic                   func,
  input  logic [7:0]             tx_byte,
  input  logic                   out_full,
  input  logic                   in_valid,
  input  logic [WORD_W-1:0]      in_word,
  input  logic                   receiver_open,
  output logic [NUM_BANKS-1:0]   bank_we,
  output logic [ROW_W-1:0]       bank_waddr,
  output logic [7:0]             bank_wdata,
  output logic                   bank_re,
  output logic [ROW_W-1:0]       bank_raddr [NUM_BANKS],
  output dcwf_meta_t             meta
);

  logic [PTR_W-1:0]  write_pointer, write_pointer_next;
  logic [PTR_W-1:0]  read_pointer, read_pointer_next;
  logic [WORD_W-1:0] inbound_remaining, inbound_remaining_next;
  logic [PTR_W-1:0]  outbound_remaining, outbound_remaining_next;

  logic [PTR_W-1:0] pending, pending_after, free_after;
  logic             full, do_push;
  logic [2:0]       rxn, ate;

  assign pending = write_pointer - read_pointer;
  assign full    = (pending == PTR_W'(BUFFER_DEPTH - 1));
  assign do_push = accept && (func == FUNC_PUSH) && !full;

  assign bank_waddr = write_pointer[PTR_W-1:LANE_W];
  assign bank_wdata = tx_byte;
  assign bank_re    = accept && (func == FUNC_POLL);

  // Lane b holds byte (b - rp) mod 4 of the window starting at read_pointer.
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      logic [LANE_W-1:0] off;
      logic [PTR_W-1:0]  addr;
      off           = LANE_W'(b) - read_pointer[LANE_W-1:0];
      addr          = read_pointer + PTR_W'(off);
      bank_raddr[b] = addr[PTR_W-1:LANE_W];
      bank_we[b]    = do_push && (write_pointer[LANE_W-1:0] == LANE_W'(b));
    end
  end

  assign rxn = (inbound_remaining < WORD_W'(4)) ? inbound_remaining[2:0] : 3'd4;
  assign ate = (outbound_remaining < PTR_W'(4)) ? outbound_remaining[2:0] : 3'd4;

  always_comb begin
    write_pointer_next      = write_pointer;
    read_pointer_next       = read_pointer;
    inbound_remaining_next  = inbound_remaining;
    outbound_remaining_next = outbound_remaining;
    meta                    = '0;
    meta.rd_lane            = read_pointer[LANE_W-1:0];

    if (accept) begin
      if (func == FUNC_PUSH) begin
        if (!full) begin
          write_pointer_next = write_pointer + PTR_W'(1);
          meta.accepted      = 1'b1;
        end
      end else begin
        if (in_valid && receiver_open) begin
          meta.in_taken = 1'b1;
          if (inbound_remaining == '0) begin
            inbound_remaining_next = in_word;
          end else begin
            meta.rx_count          = rxn;
            meta.rx_data           = in_word & byte_mask(rxn);
            inbound_remaining_next = inbound_remaining - WORD_W'(rxn);
          end
        end
        if (!out_full && (pending != '0)) begin
          meta.tx_valid = 1'b1;
          if (outbound_remaining == '0) begin
            outbound_remaining_next = pending;
            meta.tx_is_len          = 1'b1;
            meta.tx_len             = WORD_W'(pending);
          end else begin
            meta.tx_cnt             = ate;
            read_pointer_next       = read_pointer + PTR_W'(ate);
            outbound_remaining_next = outbound_remaining - PTR_W'(ate);
          end
        end
      end
    end

    pending_after      = write_pointer_next - read_pointer_next;
    free_after         = PTR_W'(BUFFER_DEPTH - 1) - pending_after;
    meta.pending_count = CNT_W'(pending_after);
    meta.free_space    = CNT_W'(free_after);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer      <= '0;
      read_pointer       <= '0;
      inbound_remaining  <= '0;
      outbound_remaining <= '0;
    end else begin
      write_pointer      <= write_pointer_next;
      read_pointer       <= read_pointer_next;
      inbound_remaining  <= inbound_remaining_next;
      outbound_remaining <= outbound_remaining_next;
    end
  end

endmodule

// ----- hdl/dcwf_out_stage.sv -----
// ----------------------------------------------------------------------------
// dcwf_out_stage
// Joins item context with store read data, packs the result word and
// buffers it in a two-entry skid toward the master port.
// ----------------------------------------------------------------------------
module dcwf_out_stage
  import dcwf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  dcwf_meta_t            meta_in,
  input  logic [7:0]            bank_rdata [NUM_BANKS],
  output logic                  ready,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic                  s1_valid;
  dcwf_meta_t            s1_meta;
  logic                  sp_valid;
  logic [OUT_DATA_W-1:0] sp_data;
  logic [OUT_DATA_W-1:0] result;
  logic [WORD_W-1:0]     packed_bytes, tx_word;
  logic                  s1_fire;

  assign ready   = !s1_valid || !sp_valid;
  assign s1_fire = s1_valid && !sp_valid;

  // Byte k of the window sits in lane (rd_lane + k) mod 4.
  always_comb begin
    for (int k = 0; k < NUM_BANKS; k++) begin
      logic [LANE_W-1:0] lane;
      lane                  = s1_meta.rd_lane + LANE_W'(k);
      packed_bytes[8*k +: 8] = bank_rdata[lane];
    end
  end

  assign tx_word = s1_meta.tx_is_len ? s1_meta.tx_len
                                     : (packed_bytes & byte_mask(s1_meta.tx_cnt));

  assign result = {4'b0, s1_meta.free_space, s1_meta.pending_count, tx_word,
                   s1_meta.tx_valid, s1_meta.rx_data, s1_meta.rx_count,
                   s1_meta.in_taken, s1_meta.accepted};

  always_ff @(posedge clk) begin
    if (ready) s1_meta <= meta_in;
    if (!sp_valid && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= result;
    end else if (sp_valid && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= sp_data;
    end
    if (s1_fire && m_axis_tvalid && !m_axis_tready) sp_data <= result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      sp_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (ready) s1_valid <= load;
      if (!m_axis_tvalid || m_axis_tready) begin
        m_axis_tvalid <= sp_valid || s1_fire;
        sp_valid      <= 1'b0;
      end else if (s1_fire) begin
        sp_valid <= 1'b1;
      end
    end
  end

endmodule

// ----- hdl/debug_channel_word_framer_unit.sv -----
// ----------------------------------------------------------------------------
// debug_channel_word_framer_unit
// Byte stream to 32-bit debug data register framer, one word per cycle if unstalled.
// ----------------------------------------------------------------------------
// Each input word is either a push (func 0: append tx_byte to the transmit
// store, which holds BUFFER_DEPTH-1 bytes) or a poll (func 1: take one
// inbound word, length first and then packed little-endian bytes, and then
// emit one outbound word: the pending count as a length, then packed bytes
// of up to four, zeroed past the frame remainder). Every input word yields
// exactly one output word. The block takes one word per clock cycle while
// the master side keeps up; each result passes through the registered read
// of the transmit store, with its context in the s1 register, and then the
// output register before m_axis_tvalid. The store is four byte-wide banks,
// so any four consecutive bytes are read together. A two-entry skid keeps
// s_axis_tready high while one finished word waits on the master side. No
// clearing pass is run after reset; unwritten store bytes are masked out.
// ----------------------------------------------------------------------------
module debug_channel_word_framer_unit
  import dcwf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] tx_byte, [8] out_full, [9] in_valid, [41:10] in_word,
  // [42] receiver_open, [47:43] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] func
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] accepted, [1] in_taken, [4:2] rx_count, [36:5] rx_data,
  // [37] tx_valid, [69:38] tx_word, [80:70] pending_count,
  // [91:81] free_space, [95:92] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic              accept;
  logic              stage_ready;
  dcwf_meta_t        meta;

  // store ports
  logic [NUM_BANKS-1:0] bank_we;
  logic [ROW_W-1:0]     bank_waddr;
  logic [7:0]           bank_wdata;
  logic                 bank_re;
  logic [ROW_W-1:0]     bank_raddr [NUM_BANKS];
  logic [7:0]           bank_rdata [NUM_BANKS];

  assign s_axis_tready = stage_ready;
  assign accept        = s_axis_tvalid && stage_ready;

  dcwf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .func          (s_axis_tuser),
    .tx_byte       (s_axis_tdata[7:0]),
    .out_full      (s_axis_tdata[8]),
    .in_valid      (s_axis_tdata[9]),
    .in_word       (s_axis_tdata[41:10]),
    .receiver_open (s_axis_tdata[42]),
    .bank_we       (bank_we),
    .bank_waddr    (bank_waddr),
    .bank_wdata    (bank_wdata),
    .bank_re       (bank_re),
    .bank_raddr    (bank_raddr),
    .meta          (meta)
  );

  // One bank per byte lane of the store address.
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    dcwf_tx_bank u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (bank_waddr),
      .wdata (bank_wdata),
      .re    (bank_re),
      .raddr (bank_raddr[b]),
      .rdata (bank_rdata[b])
    );
  end

  dcwf_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .meta_in       (meta),
    .bank_rdata    (bank_rdata),
    .ready         (stage_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- dv/debug_channel_word_framer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// debug_channel_word_framer_unit_tb
// Self-checking bench for the debug channel word framer: push and poll words
// go in on the slave stream, every accepted word is predicted against a
// mirror of the transmit store and the frame counters, and each output word
// is compared field by field in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module debug_channel_word_framer_unit_tb;
  import dcwf_pkg::*;

  // One input word plus its pacing.
  typedef struct {
    logic              func;
    logic [7:0]        tx_byte;
    logic              out_full;
    logic              in_valid;
    logic [WORD_W-1:0] in_word;
    logic              receiver_open;
    int                lead_gap;    // idle cycles before the word goes out
    bit                wait_drain;  // hold until every expected word is back
  } feed_word_t;

  // Output word, laid out as on m_axis_tdata (msb first).
  typedef struct packed {
    logic [3:0]        pad;
    logic [CNT_W-1:0]  free_space;
    logic [CNT_W-1:0]  pending_count;
    logic [WORD_W-1:0] tx_word;
    logic              tx_valid;
    logic [WORD_W-1:0] rx_data;
    logic [2:0]        rx_count;
    logic              in_taken;
    logic              accepted;
  } framer_out_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  debug_channel_word_framer_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  feed_word_t  word_feed[$];
  framer_out_t expected_out[$];
  int          mismatch_count = 0;

  // Mirror of the block state.
  logic [7:0]        mir_store [BUFFER_DEPTH];
  logic [PTR_W-1:0]  mir_wr  = '0;
  logic [PTR_W-1:0]  mir_rd  = '0;
  logic [31:0]       rx_left = '0;
  logic [31:0]       tx_left = '0;

  // Stimulus shaping: tracks the receive framing so lengths land on length
  // slots and data on data slots.
  logic [31:0] gen_rx_left = '0;
  bit          tx_calm     = 1'b0;
  bit          late_phase  = 1'b0;

  // Driver / monitor bookkeeping.
  feed_word_t cur_word;
  bit         have_word   = 1'b0;
  bit         word_taken  = 1'b0;
  int         gap_left    = 0;
  bit         result_seen = 1'b0;
  bit         rd_calm     = 1'b0;
  int         stall_left  = 0;

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor: one output word per input word, updates the mirror.
  // --------------------------------------------------------------------------
  function automatic framer_out_t predict_framer(input feed_word_t w);
    framer_out_t      r;
    logic [PTR_W-1:0] queued;
    logic [31:0]      take;
    r = '0;
    queued = mir_wr - mir_rd;
    if (w.func == FUNC_PUSH) begin
      // one slot always stays empty, so depth-1 bytes means full
      if (queued != PTR_W'(BUFFER_DEPTH - 1)) begin
        mir_store[mir_wr] = w.tx_byte;
        mir_wr = mir_wr + 1'b1;
        r.accepted = 1'b1;
      end
    end else begin
      // receive side first
      if (w.in_valid && w.receiver_open) begin
        r.in_taken = 1'b1;
        if (rx_left == 0) begin
          rx_left = w.in_word;           // length word, zero length re-arms
        end else begin
          take = (rx_left < 32'd4) ? rx_left : 32'd4;
          rx_left = rx_left - take;
          r.rx_count = take[2:0];
          for (int k = 0; k < 4; k++) begin
            r.rx_data[8*k +: 8] = (k < take) ? w.in_word[8*k +: 8] : 8'h00;
          end
        end
      end
      // then transmit
      if (!w.out_full && queued != 0) begin
        r.tx_valid = 1'b1;
        if (tx_left == 0) begin
          tx_left = 32'(queued);         // frame length = bytes pending now
          r.tx_word = tx_left;
        end else begin
          take = (tx_left < 32'd4) ? tx_left : 32'd4;
          for (int k = 0; k < 4; k++) begin
            r.tx_word[8*k +: 8] = (k < take) ? mir_store[PTR_W'(mir_rd + k)] : 8'h00;
          end
          mir_rd = PTR_W'(mir_rd + take);
          tx_left = tx_left - take;
        end
      end
    end
    queued = mir_wr - mir_rd;
    r.pending_count = CNT_W'(queued);
    r.free_space = CNT_W'(BUFFER_DEPTH - 1 - int'(queued));
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    return tx_calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      8:       return $urandom_range(13, 64);
      9:       return late_phase ? ($urandom | 32'h8000_0000) : $urandom_range(1, 4);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic feed_word_t make_word(input logic func, input logic [7:0] tx_byte,
                                           input logic out_full, input logic in_valid,
                                           input logic [31:0] in_word,
                                           input logic receiver_open);
    feed_word_t w;
    w.func          = func;
    w.tx_byte       = tx_byte;
    w.out_full      = out_full;
    w.in_valid      = in_valid;
    w.in_word       = in_word;
    w.receiver_open = receiver_open;
    w.lead_gap      = pick_gap();
    w.wait_drain    = 1'b0;
    return w;
  endfunction

  function automatic feed_word_t rand_push();
    return make_word(FUNC_PUSH, 8'($urandom), 1'($urandom), 1'($urandom), $urandom,
                     1'($urandom));
  endfunction

  // Mostly well-formed poll: receive usually possible, outbound usually free.
  function automatic feed_word_t rand_poll();
    feed_word_t w;
    w = make_word(FUNC_POLL, 8'($urandom), ($urandom_range(0, 4) == 0),
                  ($urandom_range(0, 3) != 0), 32'd0, ($urandom_range(0, 5) != 0));
    w.in_word = (gen_rx_left == 0) ? pick_length() : $urandom;
    w.wait_drain = ($urandom_range(0, 99) == 0);
    return w;
  endfunction

  // Queue a word and follow the receive framing it causes.
  task automatic queue_word(input feed_word_t w);
    logic [31:0] take;
    if (w.func == FUNC_POLL && w.in_valid && w.receiver_open) begin
      if (gen_rx_left == 0) begin
        gen_rx_left = w.in_word;
      end else begin
        take = (gen_rx_left < 32'd4) ? gen_rx_left : 32'd4;
        gen_rx_left = gen_rx_left - take;
      end
    end
    word_feed.push_back(w);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, seen);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: slave side, changes at the falling edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_out.push_back(predict_framer(cur_word));
      word_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (word_taken) begin
        word_taken = 1'b0;
        have_word  = 1'b0;
      end
      // next word, unless it must wait for the pipe to drain
      if (!have_word && word_feed.size() != 0 &&
          !(word_feed[0].wait_drain && expected_out.size() != 0)) begin
        cur_word  = word_feed.pop_front();
        have_word = 1'b1;
        gap_left  = cur_word.lead_gap;
      end
      if (have_word && gap_left == 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, cur_word.receiver_open, cur_word.in_word,
                          cur_word.in_valid, cur_word.out_full, cur_word.tx_byte};
        s_axis_tuser  <= cur_word.func;
      end else begin
        s_axis_tvalid <= 1'b0;
        if (have_word) gap_left--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: master side, ready stalls drawn per word, checks at rising edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (result_seen) begin
        result_seen = 1'b0;
        if ($urandom_range(0, 24) == 0) rd_calm = !rd_calm;
        stall_left = rd_calm ? 0 : $urandom_range(0, 14);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    framer_out_t got;
    framer_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      result_seen = 1'b1;
      got = framer_out_t'(m_axis_tdata);
      if (expected_out.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected output word, expected none, got 0x%0h",
                 $time, m_axis_tdata);
      end else begin
        want = expected_out.pop_front();
        check_field("accepted",      32'(want.accepted),      32'(got.accepted));
        check_field("in_taken",      32'(want.in_taken),      32'(got.in_taken));
        check_field("rx_count",      32'(want.rx_count),      32'(got.rx_count));
        check_field("rx_data",       want.rx_data,            got.rx_data);
        check_field("tx_valid",      32'(want.tx_valid),      32'(got.tx_valid));
        check_field("tx_word",       want.tx_word,            got.tx_word);
        check_field("pending_count", 32'(want.pending_count), 32'(got.pending_count));
        check_field("free_space",    32'(want.free_space),    32'(got.free_space));
        check_field("pad",           32'(want.pad),           32'(got.pad));
      end
    end
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    feed_word_t w;
    int         n;
    clk           = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_PUSH;
    m_axis_tready = 1'b0;

    // Directed: receive framing corner cases
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b0, 1'b0, 32'h0000_0000, 1'b1)); // idle poll
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b0, 1'b1, 32'h1234_5678, 1'b0)); // no receiver
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b0, 1'b1, 32'h0000_0000, 1'b1)); // zero length
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b0, 1'b1, 32'd7, 1'b1));
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b0, 1'b1, 32'hA1B2_C3D4, 1'b1)); // full word
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0)); // unread mid frame
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1)); // 3-byte tail
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b0, 1'b1, 32'd1, 1'b1));
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b0, 1'b1, 32'hDEAD_BEEF, 1'b1)); // 1-byte tail
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b0, 1'b1, 32'd2, 1'b1));
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b0, 1'b1, 32'h55AA_55AA, 1'b1)); // 2-byte tail
    // Directed: transmit framing
    queue_word(make_word(FUNC_PUSH, 8'h00, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1));
    queue_word(make_word(FUNC_PUSH, 8'hFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0));
    queue_word(make_word(FUNC_PUSH, 8'h5A, 1'b0, 1'b0, 32'h0000_0000, 1'b0));
    queue_word(make_word(FUNC_PUSH, 8'h81, 1'b0, 1'b0, 32'h0000_0000, 1'b0));
    queue_word(make_word(FUNC_PUSH, 8'h7E, 1'b0, 1'b0, 32'h0000_0000, 1'b0));
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b1, 1'b0, 32'h0000_0000, 1'b1)); // outbound busy
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b0, 1'b0, 32'h0000_0000, 1'b1)); // length word
    queue_word(make_word(FUNC_PUSH, 8'h33, 1'b0, 1'b0, 32'h0000_0000, 1'b0)); // lands past frame
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b1, 1'b0, 32'h0000_0000, 1'b1)); // busy mid frame
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b0, 1'b0, 32'h0000_0000, 1'b1)); // 4 bytes
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b0, 1'b0, 32'h0000_0000, 1'b1)); // 1 byte, rest 0
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b0, 1'b0, 32'h0000_0000, 1'b1)); // next length
    // receive and transmit in one poll, sent only once the pipe has drained
    w = make_word(FUNC_POLL, 8'h00, 1'b0, 1'b1, 32'd3, 1'b1);
    w.wait_drain = 1'b1;
    queue_word(w);
    queue_word(make_word(FUNC_POLL, 8'h00, 1'b0, 1'b1, 32'hCAFE_F00D, 1'b1));

    // Random: push bursts followed by poll runs, with some noise.
    n = 0;
    while (n < 675) begin
      late_phase = (n > 640);
      if ($urandom_range(0, 3) == 0) tx_calm = !tx_calm;
      repeat ($urandom_range(0, 12)) begin
        w = rand_push();
        w.wait_drain = (n == 0);
        queue_word(w);
        n++;
      end
      repeat ($urandom_range(1, 10)) begin
        queue_word(rand_poll());
        n++;
      end
      if ($urandom_range(0, 4) == 0) begin
        // noise: poll with receive blocked, all other bits random
        w = make_word(FUNC_POLL, 8'($urandom), 1'($urandom), 1'($urandom), $urandom,
                      1'($urandom));
        if (w.in_valid) w.receiver_open = 1'b0;
        queue_word(w);
        n++;
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (word_feed.size() != 0 || have_word || expected_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);   // catch stray words past the last one

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
